/* rtl/core/rntt_pkg.sv */
package rntt_pkg;

   localparam int MAX_LOG_SIZE = 6;
   localparam int MAX_SIZE     = 1 << MAX_LOG_SIZE;
   localparam int COEFF_WIDTH  = 62;
   localparam int WORD_WIDTH   = 64;
   localparam int ADDR_WIDTH   = MAX_LOG_SIZE;
   localparam int CNT_WIDTH    = MAX_LOG_SIZE + 1;
   localparam int LOG_WIDTH    = 3;
   localparam int STAGE_WIDTH  = 3;
   localparam int PROD_WIDTH   = 2 * WORD_WIDTH;
   localparam int HALF_WIDTH   = WORD_WIDTH / 2;

   typedef enum logic [1:0] {
      CSR_MODULUS     = 2'd0,
      CSR_Q_INV       = 2'd1,
      CSR_LOG_SIZE    = 2'd2,
      CSR_REDUCE_MODE = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      WR_LOAD = 2'd0,
      WR_DIFF = 2'd1,
      WR_SUM  = 2'd2
   } wr_sel_type;

   typedef enum logic [1:0] {
      MS_FIRST  = 2'd0,
      MS_SECOND = 2'd1,
      MS_THIRD  = 2'd2
   } mul_step_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_READ,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_FIX,
      ST_WR_HI,
      ST_WR_LO,
      ST_EMIT_RD,
      ST_EMIT_SHOW
   } state_type;

   typedef struct packed {
      logic                  load_we;
      logic                  wr_en;
      wr_sel_type            wr_sel;
      logic [ADDR_WIDTH-1:0] wr_addr;
      logic                  rd_en;
      logic [ADDR_WIDTH-1:0] rd_addr_a;
      logic [ADDR_WIDTH-1:0] rd_addr_b;
      logic [ADDR_WIDTH-1:0] tw_addr;
      logic                  mul_start;
      logic                  capture;
      mul_step_type          mul_step;
      logic                  fix;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
   } stat_type;

   function automatic logic [LOG_WIDTH-1:0] row_log(input logic [LOG_WIDTH-1:0] lg);
      logic [LOG_WIDTH-1:0] r;
      r = lg;
      if (lg == '0) begin
         r = LOG_WIDTH'(1);
      end else if (lg > LOG_WIDTH'(MAX_LOG_SIZE)) begin
         r = LOG_WIDTH'(MAX_LOG_SIZE);
      end
      return r;
   endfunction

endpackage

/* rtl/core/rntt_mul.sv */
module rntt_mul (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [rntt_pkg::WORD_WIDTH-1:0]    op_a,
   input  logic [rntt_pkg::WORD_WIDTH-1:0]    op_b,
   output logic [rntt_pkg::PROD_WIDTH-1:0]    product,
   output logic                               done
);

   localparam int HW = rntt_pkg::HALF_WIDTH;

   logic [rntt_pkg::WORD_WIDTH-1:0] a_ff, b_ff;
   logic [rntt_pkg::PROD_WIDTH-1:0] acc_ff, acc_in;
   logic [rntt_pkg::WORD_WIDTH-1:0] pp_ff, pp_in;
   logic [1:0]                      cnt_ff, pidx_ff;
   logic                            run_ff, pv_ff, done_ff;
   logic [HW-1:0]                   pa, pb;
   logic [rntt_pkg::PROD_WIDTH-1:0] pp_wide;

   always_comb begin
      pa = cnt_ff[1] ? a_ff[2*HW-1:HW] : a_ff[HW-1:0];
      pb = cnt_ff[0] ? b_ff[2*HW-1:HW] : b_ff[HW-1:0];
      pp_in = pa * pb;
   end

   always_comb begin
      pp_wide = rntt_pkg::PROD_WIDTH'(pp_ff);
      case (pidx_ff)
         2'd0:    acc_in = acc_ff + pp_wide;
         2'd3:    acc_in = acc_ff + (pp_wide << (2 * HW));
         default: acc_in = acc_ff + (pp_wide << HW);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         pv_ff   <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         pv_ff   <= run_ff;
         done_ff <= pv_ff && (pidx_ff == 2'd3);
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= op_a;
         b_ff   <= op_b;
         acc_ff <= '0;
      end else if (pv_ff) begin
         acc_ff <= acc_in;
      end
      pp_ff   <= pp_in;
      pidx_ff <= cnt_ff;
   end

   assign product = acc_ff;
   assign done    = done_ff;

endmodule

/* rtl/core/rntt_dp.sv */
module rntt_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  rntt_pkg::cmd_type                   cmd,
   input  logic [rntt_pkg::COEFF_WIDTH-1:0]    coeff_in,
   input  logic [rntt_pkg::COEFF_WIDTH-1:0]    twiddle,
   input  logic [rntt_pkg::WORD_WIDTH-1:0]     twiddle_quot,
   input  logic [rntt_pkg::COEFF_WIDTH-1:0]    modulus,
   input  logic [rntt_pkg::WORD_WIDTH-1:0]     q_inv,
   input  logic                                reduce_mode,
   output logic [rntt_pkg::COEFF_WIDTH-1:0]    coeff_out,
   output rntt_pkg::stat_type                  stat
);

   localparam int W  = rntt_pkg::WORD_WIDTH;
   localparam int CW = rntt_pkg::COEFF_WIDTH;

   logic [CW-1:0] coeff_mem [rntt_pkg::MAX_SIZE];
   logic [CW-1:0] tw_mem    [rntt_pkg::MAX_SIZE];
   logic [W-1:0]  qt_mem    [rntt_pkg::MAX_SIZE];

   logic [CW-1:0] ua_ff, xb_ff, w_ff;
   logic [W-1:0]  r_ff, h_ff, p_ff, t_ff, v_ff;
   logic [W-1:0]  u64, x64, w64, q64;
   logic [W-1:0]  mul_a, mul_b;
   logic [rntt_pkg::PROD_WIDTH-1:0] prod;
   logic [W-1:0]  prod_lo, prod_hi;
   logic [W:0]    lo_sum;
   logic [W-1:0]  sum_raw, sum_red, diff;
   logic [CW-1:0] wdata;
   logic          mul_done;

   assign u64 = W'(ua_ff);
   assign x64 = W'(xb_ff);
   assign w64 = W'(w_ff);
   assign q64 = W'(modulus);
   assign prod_lo = prod[W-1:0];
   assign prod_hi = prod[2*W-1:W];
   assign lo_sum  = {1'b0, p_ff} + {1'b0, prod_lo};

   always_comb begin
      mul_a = x64;
      mul_b = r_ff;
      case (cmd.mul_step)
         rntt_pkg::MS_FIRST: begin
            mul_a = x64;
            mul_b = reduce_mode ? w64 : r_ff;
         end
         rntt_pkg::MS_SECOND: begin
            mul_a = reduce_mode ? p_ff : x64;
            mul_b = reduce_mode ? q_inv : w64;
         end
         rntt_pkg::MS_THIRD: begin
            mul_a = reduce_mode ? t_ff : h_ff;
            mul_b = q64;
         end
         default: begin
            mul_a = x64;
            mul_b = r_ff;
         end
      endcase
   end

   rntt_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod),
      .done    (mul_done)
   );

   always_comb begin
      sum_raw = u64 + v_ff;
      sum_red = (sum_raw >= q64) ? (sum_raw - q64) : sum_raw;
      diff    = (u64 >= v_ff) ? (u64 - v_ff) : (u64 + q64 - v_ff);
      case (cmd.wr_sel)
         rntt_pkg::WR_LOAD: wdata = coeff_in;
         rntt_pkg::WR_DIFF: wdata = diff[CW-1:0];
         rntt_pkg::WR_SUM:  wdata = sum_red[CW-1:0];
         default:           wdata = coeff_in;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         coeff_mem[cmd.wr_addr] <= wdata;
      end
      if (cmd.load_we) begin
         tw_mem[cmd.wr_addr] <= twiddle;
         qt_mem[cmd.wr_addr] <= twiddle_quot;
      end
      if (cmd.rd_en) begin
         ua_ff <= coeff_mem[cmd.rd_addr_a];
         xb_ff <= coeff_mem[cmd.rd_addr_b];
         w_ff  <= tw_mem[cmd.tw_addr];
         r_ff  <= qt_mem[cmd.tw_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         case (cmd.mul_step)
            rntt_pkg::MS_FIRST: begin
               h_ff <= prod_hi;
               p_ff <= prod_lo;
            end
            rntt_pkg::MS_SECOND: begin
               p_ff <= reduce_mode ? p_ff : prod_lo;
               t_ff <= prod_lo;
            end
            rntt_pkg::MS_THIRD: begin
               v_ff <= reduce_mode ? (h_ff + prod_hi + W'(lo_sum[W])) : (p_ff - prod_lo);
            end
            default: begin
               v_ff <= v_ff;
            end
         endcase
      end else if (cmd.fix) begin
         v_ff <= (v_ff >= q64) ? (v_ff - q64) : v_ff;
      end
   end

   assign coeff_out     = ua_ff;
   assign stat.mul_done = mul_done;

endmodule

/* rtl/core/rntt_ctrl.sv */
module rntt_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [rntt_pkg::LOG_WIDTH-1:0]      log_size,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rntt_pkg::ADDR_WIDTH-1:0]     rsp_position,
   output logic                                rsp_last,
   input  rntt_pkg::stat_type                  stat,
   output rntt_pkg::cmd_type                   cmd
);

   localparam int AW = rntt_pkg::ADDR_WIDTH;
   localparam int CN = rntt_pkg::CNT_WIDTH;
   localparam int LW = rntt_pkg::LOG_WIDTH;

   rntt_pkg::state_type    state_ff, state_in;
   rntt_pkg::mul_step_type step_ff, step_in;
   logic [CN-1:0]          load_ff, load_in;
   logic [LW-1:0]          lg_ff, lg_in;
   logic [LW-1:0]          s_ff, s_in;
   logic [AW-1:0]          b_ff, b_in;
   logic [AW-1:0]          k_ff, k_in;

   logic [LW-1:0] lg_now, logt;
   logic [CN-1:0] n_now, load_next;
   logic [AW-1:0] tmask, lo_addr, hi_addr, tw_addr, half_last, n_last;

   always_comb begin
      lg_now    = rntt_pkg::row_log(log_size);
      n_now     = CN'(1) << lg_now;
      load_next = load_ff + CN'(1);
      logt      = lg_ff - s_ff - LW'(1);
      tmask     = (AW'(1) << logt) - AW'(1);
      lo_addr   = b_ff + (b_ff & ~tmask);
      hi_addr   = lo_addr + tmask + AW'(1);
      tw_addr   = (AW'(1) << s_ff) + (b_ff >> logt);
      half_last = (AW'(1) << (lg_ff - LW'(1))) - AW'(1);
      n_last    = AW'((CN'(1) << lg_ff) - CN'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rntt_pkg::ST_LOAD;
         step_ff  <= rntt_pkg::MS_FIRST;
         load_ff  <= '0;
         lg_ff    <= LW'(rntt_pkg::MAX_LOG_SIZE);
         s_ff     <= '0;
         b_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         load_ff  <= load_in;
         lg_ff    <= lg_in;
         s_ff     <= s_in;
         b_ff     <= b_in;
         k_ff     <= k_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      load_in  = load_ff;
      lg_in    = lg_ff;
      s_in     = s_ff;
      b_in     = b_ff;
      k_in     = k_ff;

      req_tready = 1'b0;
      rsp_tvalid = 1'b0;

      cmd           = '0;
      cmd.wr_sel    = rntt_pkg::WR_LOAD;
      cmd.mul_step  = step_ff;
      cmd.wr_addr   = load_ff[AW-1:0];
      cmd.rd_addr_a = lo_addr;
      cmd.rd_addr_b = hi_addr;
      cmd.tw_addr   = tw_addr;

      case (state_ff)
         rntt_pkg::ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.wr_en   = 1'b1;
               cmd.load_we = 1'b1;
               if (load_next >= n_now) begin
                  load_in  = '0;
                  lg_in    = lg_now;
                  s_in     = '0;
                  b_in     = '0;
                  state_in = rntt_pkg::ST_READ;
               end else begin
                  load_in = load_next;
               end
            end
         end
         rntt_pkg::ST_READ: begin
            cmd.rd_en = 1'b1;
            step_in   = rntt_pkg::MS_FIRST;
            state_in  = rntt_pkg::ST_MUL_GO;
         end
         rntt_pkg::ST_MUL_GO: begin
            cmd.mul_start = 1'b1;
            state_in      = rntt_pkg::ST_MUL_WAIT;
         end
         rntt_pkg::ST_MUL_WAIT: begin
            if (stat.mul_done) begin
               cmd.capture = 1'b1;
               case (step_ff)
                  rntt_pkg::MS_FIRST: begin
                     step_in  = rntt_pkg::MS_SECOND;
                     state_in = rntt_pkg::ST_MUL_GO;
                  end
                  rntt_pkg::MS_SECOND: begin
                     step_in  = rntt_pkg::MS_THIRD;
                     state_in = rntt_pkg::ST_MUL_GO;
                  end
                  default: begin
                     state_in = rntt_pkg::ST_FIX;
                  end
               endcase
            end
         end
         rntt_pkg::ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = rntt_pkg::ST_WR_HI;
         end
         rntt_pkg::ST_WR_HI: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = rntt_pkg::WR_DIFF;
            cmd.wr_addr = hi_addr;
            state_in    = rntt_pkg::ST_WR_LO;
         end
         rntt_pkg::ST_WR_LO: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = rntt_pkg::WR_SUM;
            cmd.wr_addr = lo_addr;
            state_in    = rntt_pkg::ST_READ;
            if (b_ff == half_last) begin
               b_in = '0;
               if (s_ff == lg_ff - LW'(1)) begin
                  k_in     = '0;
                  state_in = rntt_pkg::ST_EMIT_RD;
               end else begin
                  s_in = s_ff + LW'(1);
               end
            end else begin
               b_in = b_ff + AW'(1);
            end
         end
         rntt_pkg::ST_EMIT_RD: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_addr_a = k_ff;
            state_in      = rntt_pkg::ST_EMIT_SHOW;
         end
         rntt_pkg::ST_EMIT_SHOW: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (k_ff == n_last) begin
                  k_in     = '0;
                  state_in = rntt_pkg::ST_LOAD;
               end else begin
                  k_in     = k_ff + AW'(1);
                  state_in = rntt_pkg::ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = rntt_pkg::ST_LOAD;
         end
      endcase
   end

   assign rsp_position = k_ff;
   assign rsp_last     = (k_ff == n_last);

endmodule

/* rtl/core/row_ntt_cooley_tukey_core.sv */
// Forward radix-2 Cooley-Tukey NTT over one row of 2^log_size coefficients (2 to 64) modulo q.
// Load the row one coefficient per req item together with the twiddle of the same index
// (bit-reversed table, entry 0 unused) and its Shoup quotient; the last item of the row starts
// the transform, and the row then leaves on rsp in array order (bit-reversed spectrum), with
// tlast on its final item. Loading accepts one item per cycle. Each butterfly uses
// three 64x64 products, each built from four 32x32 partial products on one shared multiplier,
// plus a read, a correction step and writes of the high and then the low result through the
// single write port of the coefficient store. Each result item is read from the store and then
// offered, and the next one is read only after the previous one has been taken.
// Configuration writes are taken at any time but are only meant while the block is idle.
module row_ntt_cooley_tukey_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [191:0] req_tdata,   // coeff_in[61:0], twiddle[123:62], twiddle_quot[187:124]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,   // coeff_out[61:0], position[67:62]
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_data
);

   localparam int CW = rntt_pkg::COEFF_WIDTH;
   localparam int W  = rntt_pkg::WORD_WIDTH;
   localparam int LW = rntt_pkg::LOG_WIDTH;

   logic [CW-1:0] modulus_ff;
   logic [W-1:0]  q_inv_ff;
   logic [LW-1:0] log_size_ff;
   logic          mode_ff;

   rntt_pkg::cmd_type  cmd;
   rntt_pkg::stat_type stat;
   logic [CW-1:0]                    coeff_out;
   logic [rntt_pkg::ADDR_WIDTH-1:0]  position;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= CW'(3);
         q_inv_ff    <= '0;
         log_size_ff <= LW'(rntt_pkg::MAX_LOG_SIZE);
         mode_ff     <= 1'b0;
      end else if (csr_valid) begin
         case (rntt_pkg::csr_index_type'(csr_index))
            rntt_pkg::CSR_MODULUS:     modulus_ff  <= csr_data[CW-1:0];
            rntt_pkg::CSR_Q_INV:       q_inv_ff    <= csr_data;
            rntt_pkg::CSR_LOG_SIZE:    log_size_ff <= csr_data[LW-1:0];
            rntt_pkg::CSR_REDUCE_MODE: mode_ff     <= csr_data[0];
            default:                   mode_ff     <= mode_ff;
         endcase
      end
   end

   rntt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .log_size     (log_size_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_position (position),
      .rsp_last     (rsp_tlast),
      .stat         (stat),
      .cmd          (cmd)
   );

   rntt_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .coeff_in     (req_tdata[61:0]),
      .twiddle      (req_tdata[123:62]),
      .twiddle_quot (req_tdata[187:124]),
      .modulus      (modulus_ff),
      .q_inv        (q_inv_ff),
      .reduce_mode  (mode_ff),
      .coeff_out    (coeff_out),
      .stat         (stat)
   );

   assign rsp_tdata = {4'b0000, position, coeff_out};

endmodule

/* rtl/core/rntt_checker.sv */
module rntt_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [191:0] req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [71:0]  rsp_tdata,
   input logic         rsp_tlast,
   input logic         csr_valid,
   input logic         csr_ready,
   input logic [1:0]   csr_index,
   input logic [63:0]  csr_data
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result item offered straight after reset");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("loading while a result item is offered");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result item changed");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> ##1
         rsp_tvalid && (rsp_tdata[67:62] == 6'($past(rsp_tdata[67:62], 2) + 6'd1)))
      else $error("result positions out of order");

   a_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("no return to loading after the last result item");

endmodule

bind row_ntt_cooley_tukey_core rntt_checker u_rntt_checker (.*);
